// ===== rtl/mwh_pkg.sv =====
// shared types and constants for the mutex with waiter handoff
`default_nettype none

package mwh_pkg;

    localparam int TASK_COUNT_DEF = 4;
    localparam int ID_W           = 2;
    localparam int TICKS_W        = 32;

    typedef enum logic [2:0] {
        OP_TRY     = 3'd0,
        OP_BLOCK   = 3'd1,
        OP_TIMED   = 3'd2,
        OP_RELEASE = 3'd3,
        OP_RESUME  = 3'd4
    } t_op;

    typedef enum logic [2:0] {
        ST_GRANTED   = 3'd0,
        ST_FAILED    = 3'd1,
        ST_BLOCKED   = 3'd2,
        ST_FREED     = 3'd3,
        ST_NOT_OWNER = 3'd4,
        ST_HANDED    = 3'd5
    } t_status;

    typedef enum logic [1:0] {
        TM_NONE  = 2'd0,
        TM_ARM   = 2'd1,
        TM_CLEAR = 2'd2
    } t_timer;

    typedef struct packed {
        t_status             status;
        logic                wake_valid;
        logic [ID_W-1:0]     wake_task;
        logic                yield_request;
        t_timer              timer_action;
        logic [TICKS_W-1:0]  timer_ticks;
    } t_result;

endpackage

`default_nettype wire

// ===== rtl/mwh_core.sv =====
// mutex state (lock, owner, waiter mask) and per-request decision logic
`default_nettype none

module mwh_core #(
    parameter int TASK_COUNT = mwh_pkg::TASK_COUNT_DEF
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_fire,
    input  wire logic [2:0]                   i_operation,
    input  wire logic [mwh_pkg::ID_W-1:0]     i_task_id,
    input  wire logic [mwh_pkg::TICKS_W-1:0]  i_timeout_ticks,
    output mwh_pkg::t_result                  o_result
);

    import mwh_pkg::*;

    logic                  r_locked;
    logic [ID_W-1:0]       r_owner;
    logic [TASK_COUNT-1:0] r_waiting;

    logic                  n_locked;
    logic [ID_W-1:0]       n_owner;
    logic [TASK_COUNT-1:0] n_waiting;

    t_op                   op;
    t_result               res;
    logic                  tid_ok;
    logic [TASK_COUNT-1:0] tid_oh;
    logic [TASK_COUNT-1:0] pick_oh;
    logic [ID_W-1:0]       pick_idx;

    assign op     = t_op'(i_operation);
    assign tid_ok = int'(i_task_id) < TASK_COUNT;

    // lowest set waiter bit isolated, then encoded
    assign pick_oh = r_waiting & (~r_waiting + TASK_COUNT'(1));

    always_comb begin
        pick_idx = '0;
        for (int i = 0; i < TASK_COUNT; i++) begin
            tid_oh[i] = (int'(i_task_id) == i);
            if (pick_oh[i]) begin
                pick_idx = pick_idx | ID_W'(i);
            end
        end
    end

    always_comb begin
        n_locked  = r_locked;
        n_owner   = r_owner;
        n_waiting = r_waiting;
        res       = '{status: ST_FAILED, wake_valid: 1'b0, wake_task: '0,
                      yield_request: 1'b0, timer_action: TM_NONE, timer_ticks: '0};
        if (!tid_ok) begin
            res.status = (op == OP_RELEASE) ? ST_NOT_OWNER : ST_FAILED;
        end else begin
            case (op)
                OP_TRY, OP_BLOCK, OP_TIMED: begin
                    if (!r_locked) begin
                        n_locked   = 1'b1;
                        n_owner    = i_task_id;
                        res.status = ST_GRANTED;
                    end else if (op == OP_TRY) begin
                        res.status = ST_FAILED;
                    end else if (op == OP_TIMED && i_timeout_ticks == '0) begin
                        res.status = ST_FAILED;
                    end else begin
                        n_waiting         = r_waiting | tid_oh;
                        res.status        = ST_BLOCKED;
                        res.yield_request = 1'b1;
                        if (op == OP_TIMED) begin
                            res.timer_action = TM_ARM;
                            res.timer_ticks  = i_timeout_ticks;
                        end
                    end
                end
                OP_RELEASE: begin
                    if (!r_locked || r_owner != i_task_id) begin
                        res.status = ST_NOT_OWNER;
                    end else if (|r_waiting) begin
                        // direct handoff to the lowest-numbered waiter
                        n_waiting         = r_waiting & ~pick_oh;
                        n_owner           = pick_idx;
                        res.status        = ST_HANDED;
                        res.wake_valid    = 1'b1;
                        res.wake_task     = pick_idx;
                        res.yield_request = 1'b1;
                    end else begin
                        n_locked   = 1'b0;
                        n_owner    = '0;
                        res.status = ST_FREED;
                    end
                end
                OP_RESUME: begin
                    if (r_locked && r_owner == i_task_id) begin
                        res.status       = ST_GRANTED;
                        res.timer_action = TM_CLEAR;
                    end else begin
                        n_waiting  = r_waiting & ~tid_oh;
                        res.status = ST_FAILED;
                    end
                end
                default: begin
                    res.status = ST_FAILED;
                end
            endcase
        end
    end

    assign o_result = res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_locked  <= 1'b0;
            r_owner   <= '0;
            r_waiting <= '0;
        end else if (i_fire) begin
            r_locked  <= n_locked;
            r_owner   <= n_owner;
            r_waiting <= n_waiting;
        end
    end

`ifndef SYNTHESIS
    // waiters only exist behind a held lock
    a_free_no_waiters: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_locked |-> r_waiting == '0)
        else $error("waiter mask set while mutex is free");

    a_handoff_owner: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_fire && res.wake_valid |=> r_locked && r_owner == $past(res.wake_task))
        else $error("handed-over task is not the new owner");

    a_handoff_clears_waiter: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_fire && res.wake_valid |=> (r_waiting & $past(pick_oh)) == '0)
        else $error("woken task still marked as waiting");

    a_arm_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_fire && res.timer_action == TM_ARM |-> res.timer_ticks != '0)
        else $error("countdown armed with zero ticks");
`endif

endmodule

`default_nettype wire

// ===== rtl/mutex_with_waiter_handoff_unit.sv =====
// mutex with waiter handoff: input register, decision core, result register
// Usage:
//   request channel: i_in_valid / o_in_stall with i_operation, i_task_id and
//   i_timeout_ticks; a request transfers on a rising edge with valid high and
//   stall low.
//   result channel: o_out_valid / i_out_stall with status, wake, yield and timer
//   fields; exactly one result per request, in request order.
// Timing:
//   a request is registered in the input register at its transfer, decided
//   against the current mutex state once it can leave that register, and its
//   result is registered in the result register, from which it can transfer.
//   One request per cycle is sustained while i_out_stall is low; the single
//   decision stage updates lock, owner and waiter mask as each request leaves
//   the input register.
// Reset:
//   mutex is free, no owner, no waiters, both pipeline stages empty.
// Stall:
//   while i_out_stall holds a waiting result, the input register still takes one
//   request; after that o_in_stall rises until the result transfers.
`default_nettype none

module mutex_with_waiter_handoff_unit #(
    parameter int TASK_COUNT = mwh_pkg::TASK_COUNT_DEF
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_in_valid,
    output      logic                         o_in_stall,
    input  wire logic [2:0]                   i_operation,
    input  wire logic [mwh_pkg::ID_W-1:0]     i_task_id,
    input  wire logic [mwh_pkg::TICKS_W-1:0]  i_timeout_ticks,
    output      logic                         o_out_valid,
    input  wire logic                         i_out_stall,
    output      logic [2:0]                   o_status,
    output      logic                         o_wake_valid,
    output      logic [mwh_pkg::ID_W-1:0]     o_wake_task,
    output      logic                         o_yield_request,
    output      logic [1:0]                   o_timer_action,
    output      logic [mwh_pkg::TICKS_W-1:0]  o_timer_ticks
);

    import mwh_pkg::*;

    logic                r_in_valid;
    logic [2:0]          r_op;
    logic [ID_W-1:0]     r_tid;
    logic [TICKS_W-1:0]  r_ticks;
    logic                r_out_valid;
    t_result             r_res;

    logic                advance;
    logic                fire;
    t_result             core_res;

    assign advance    = !r_out_valid || !i_out_stall;
    assign fire       = r_in_valid && advance;
    assign o_in_stall = r_in_valid && !advance;

    mwh_core #(
        .TASK_COUNT (TASK_COUNT)
    ) u_core (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_fire          (fire),
        .i_operation     (r_op),
        .i_task_id       (r_tid),
        .i_timeout_ticks (r_ticks),
        .o_result        (core_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (!o_in_stall) begin
                r_in_valid <= i_in_valid;
            end
            if (advance) begin
                r_out_valid <= r_in_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) begin
            r_op    <= i_operation;
            r_tid   <= i_task_id;
            r_ticks <= i_timeout_ticks;
        end
        if (fire) begin
            r_res <= core_res;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_status        = r_res.status;
    assign o_wake_valid    = r_res.wake_valid;
    assign o_wake_task     = r_res.wake_task;
    assign o_yield_request = r_res.yield_request;
    assign o_timer_action  = r_res.timer_action;
    assign o_timer_ticks   = r_res.timer_ticks;

endmodule

`default_nettype wire
